/* design/key_press_classifier_defines.svh */
// key_press_classifier_defines.svh: assertion macros for the key classifier RTL, used by kpc_core.
// No dependencies; expects i_clk and i_rst_n in the including module.
`ifndef KEY_PRESS_CLASSIFIER_DEFINES_SVH
`define KEY_PRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define KPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define KPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/kpc_pkg.sv */
// kpc_pkg.sv: types, constants and the key priority encoder for the key classifier.
// No dependencies.
`default_nettype none

package kpc_pkg;

    localparam int KEY_W        = 7;
    localparam int ID_W         = 3;
    localparam int EV_W         = 2;
    localparam int DEB_W        = 8;
    localparam int TICK_W       = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int NUM_KEYS_DEF = 7;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd5;
    localparam logic [TICK_W-1:0] HOLD_RESET     = 16'd1600;
    localparam logic [TICK_W-1:0] TICK_MAX       = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 1'b1;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE     = 2'd0;
    localparam logic [EV_W-1:0] EV_SHORT    = 2'd1;
    localparam logic [EV_W-1:0] EV_HOLD     = 2'd2;
    localparam logic [EV_W-1:0] EV_HOLD_END = 2'd3;

    localparam logic [ID_W-1:0] KEY_NONE = 3'd0;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [TICK_W-1:0] hold_ticks;
    } t_kpc_cfg;

    typedef struct packed {
        logic [EV_W-1:0] event_code;
        logic [ID_W-1:0] key_id;
    } t_kpc_result;

    // lowest pressed bit wins; returns key id 1..7, 0 when nothing pressed
    function automatic logic [ID_W-1:0] first_pressed(input logic [KEY_W-1:0] pressed);
        logic [ID_W-1:0] id;
        id = KEY_NONE;
        for (int i = KEY_W - 1; i >= 0; i--) begin
            if (pressed[i]) begin
                id = ID_W'(i + 1);
            end
        end
        return id;
    endfunction

endpackage

`default_nettype wire

/* design/key_press_classifier.sv */
// key_press_classifier.sv: top level; stream handshake, input and result registers, config.
// Depends on kpc_pkg, kpc_core and key_press_classifier_defines.svh (through kpc_core).
`default_nettype none

// Key press classifier. Each request on the slave stream carries one scan tick:
// the active-low levels of up to seven keys (bit 0 up, then down, left, right,
// center, next, bit 6 last). Every tick gives exactly one result on the master
// stream: an event code (none, short press, holding, hold released) and the key
// id, which is zero when there is no event. A key that stays low for
// debounce_ticks ticks is latched, lowest bit first; releasing it before
// hold_ticks gives a short press, otherwise a holding event comes every tick
// from hold_ticks on and the release gives a hold-released event. The tick
// counter saturates at 65535. If every key is up when the debounce count runs
// out the scanner goes back to idle with no event.
// Rate: one tick per clock cycle sustained while the master side takes every result.
// A tick goes into the input register, then the state update and classification
// run combinationally into the result register, so a result is valid on the
// master stream once its tick has passed the input and result registers. While
// a result waits on i_m_tready the input register still takes one more tick, then
// the slave side stalls until the result is taken.
// Configuration: register 0 is debounce_ticks (8 bit, reset 5), register 1 is
// hold_ticks (16 bit, reset 1600); write them only while no tick is in flight.
module key_press_classifier
    import kpc_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // slave stream: tdata[6:0] keys_level, tdata[7] zero
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [7:0]            i_s_tdata,
    // master stream: tdata[1:0] event_code, tdata[4:2] key_id, tdata[7:5] zero
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [7:0]                 o_m_tdata,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // input register
    logic             r_in_valid;
    logic [KEY_W-1:0] r_in_keys;

    // result register
    logic             r_out_valid;
    t_kpc_result      r_out;

    t_kpc_cfg         r_cfg;
    t_kpc_result      result;
    logic             step;

    // a tick moves on when the result register is free or being emptied
    assign step       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{debounce_ticks: DEBOUNCE_RESET, hold_ticks: HOLD_RESET};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_cfg.debounce_ticks <= i_cfg_data[DEB_W-1:0];
                CFG_HOLD:     r_cfg.hold_ticks     <= i_cfg_data[TICK_W-1:0];
                default:      r_cfg                <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_keys <= i_s_tdata[KEY_W-1:0];
        end
    end

    kpc_core #(
        .NUM_KEYS (NUM_KEYS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_keys_level (r_in_keys),
        .i_cfg        (r_cfg),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.key_id, r_out.event_code};

endmodule

`default_nettype wire

/* design/kpc_core.sv */
// kpc_core.sv: scan state (phase, tick counter, latched key) and per-tick classification.
// Depends on kpc_pkg and key_press_classifier_defines.svh.
`default_nettype none
`include "key_press_classifier_defines.svh"

module kpc_core
    import kpc_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic [KEY_W-1:0]   i_keys_level,
    input  wire t_kpc_cfg           i_cfg,
    output t_kpc_result             o_result
);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_LATCHED  = 2'd2
    } t_phase;

    localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((1 << NUM_KEYS) - 1);

    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic [ID_W-1:0]   r_key,   n_key;

    logic [KEY_W-1:0]  pressed;
    logic              any_down;

    assign pressed  = ~i_keys_level & KEY_MASK;
    assign any_down = |pressed;

    always_comb begin
        n_phase  = r_phase;
        n_ticks  = r_ticks;
        n_key    = r_key;
        o_result = '{event_code: EV_NONE, key_id: KEY_NONE};

        if (n_phase == PH_IDLE && any_down) begin
            n_phase = PH_DEBOUNCE;
        end

        if (n_phase != PH_IDLE) begin
            if (n_ticks != TICK_MAX) begin
                n_ticks = n_ticks + 1'b1;
            end

            if (n_phase == PH_DEBOUNCE && n_ticks >= TICK_W'(i_cfg.debounce_ticks)) begin
                if (any_down) begin
                    n_key   = first_pressed(pressed);
                    n_phase = PH_LATCHED;
                end else begin
                    // key gone before debounce end: drop it silently
                    n_phase = PH_IDLE;
                    n_ticks = '0;
                    n_key   = KEY_NONE;
                end
            end

            if (n_phase == PH_LATCHED && !any_down && n_ticks < i_cfg.hold_ticks) begin
                o_result = '{event_code: EV_SHORT, key_id: n_key};
                n_phase  = PH_IDLE;
                n_ticks  = '0;
                n_key    = KEY_NONE;
            end

            if (n_phase == PH_LATCHED && n_ticks >= i_cfg.hold_ticks) begin
                if (any_down) begin
                    o_result = '{event_code: EV_HOLD, key_id: n_key};
                end else begin
                    o_result = '{event_code: EV_HOLD_END, key_id: n_key};
                    n_phase  = PH_IDLE;
                    n_ticks  = '0;
                    n_key    = KEY_NONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ticks <= '0;
            r_key   <= KEY_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_key   <= n_key;
        end
    end

    `KPC_ASSERT_NOW(a_idle_clear, r_phase == PH_IDLE, r_ticks == '0 && r_key == KEY_NONE, "idle with live counter or key")
    `KPC_ASSERT_NOW(a_latched_key, r_phase == PH_LATCHED, r_key != KEY_NONE, "latched without a key")
    `KPC_ASSERT_NOW(a_event_key, i_step, (o_result.event_code == EV_NONE) == (o_result.key_id == KEY_NONE), "event and key id disagree")
    `KPC_ASSERT_NEXT(a_release_idle, i_step && (o_result.event_code == EV_SHORT || o_result.event_code == EV_HOLD_END), r_phase == PH_IDLE, "release did not return to idle")

endmodule

`default_nettype wire

/* sim/key_press_classifier_test.sv */
// key_press_classifier_test.sv: self-checking testbench for the key press classifier.
// Depends on kpc_pkg and key_press_classifier; drives scan ticks, checks every event result.
`default_nettype none

// Scan ticks go in on the slave stream, one classification result per tick comes back on
// the master stream. A shadow scanner tracks phase, tick count and latched key and
// predicts each result when its tick request is taken; the monitor checks results in order.
module key_press_classifier_test;
    import kpc_pkg::*;

    localparam int STALL_LIMIT   = 500;  // cycles without any handshake before giving up
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 8;    // quiet cycles at the end of each drain
    localparam int PHASE_TICKS   = 150;  // random ticks per config setting
    localparam logic [KEY_W-1:0] ALL_UP = '1;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_DEBOUNCE,
        SCAN_LATCHED
    } t_scan_phase;

    // ---------------------------------------------------------------- DUT ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata   = 8'h7F;  // [6:0] keys_level, [7] zero
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [7:0]            o_m_tdata;            // [1:0] event_code, [4:2] key_id, [7:5] zero
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_DEBOUNCE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    key_press_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------- shadow scanner
    t_scan_phase       scan_st   = SCAN_IDLE;
    logic [TICK_W-1:0] press_cnt = '0;
    logic [ID_W-1:0]   held_key  = KEY_NONE;
    logic [DEB_W-1:0]  deb_reg   = DEBOUNCE_RESET;
    logic [TICK_W-1:0] hold_reg  = HOLD_RESET;

    logic [KEY_W-1:0] pending_ticks[$];    // tick levels not yet offered
    t_kpc_result      expected_events[$];  // predicted results, oldest first

    logic tick_accepted = 1'b0;  // slave request taken at the last rising edge
    logic result_taken  = 1'b0;  // master request taken at the last rising edge
    int   mismatches    = 0;
    int   idle_cycles   = 0;
    int   send_wait     = 0;
    int   send_burst    = 0;
    int   recv_wait     = 0;
    int   recv_burst    = 0;

    // One scan tick: advance the shadow state and return the event it gives.
    function automatic t_kpc_result classify_tick(input logic [KEY_W-1:0] level);
        logic [KEY_W-1:0] down;
        t_kpc_result      res;
        down           = ~level;
        res.event_code = EV_NONE;
        res.key_id     = KEY_NONE;
        if (scan_st == SCAN_IDLE && down != '0) begin
            scan_st = SCAN_DEBOUNCE;
        end
        if (scan_st != SCAN_IDLE) begin
            if (press_cnt != TICK_MAX) begin
                press_cnt++;
            end
            // debounce end: latch lowest pressed key, or drop back if all keys are up
            if (scan_st == SCAN_DEBOUNCE && press_cnt >= TICK_W'(deb_reg)) begin
                if (down != '0) begin
                    held_key = KEY_NONE;
                    for (int i = 0; i < KEY_W; i++) begin
                        if (down[i] && held_key == KEY_NONE) begin
                            held_key = ID_W'(i + 1);
                        end
                    end
                    scan_st = SCAN_LATCHED;
                end else begin
                    scan_st   = SCAN_IDLE;
                    press_cnt = '0;
                    held_key  = KEY_NONE;
                end
            end
            // released before the hold count: short press
            if (scan_st == SCAN_LATCHED && down == '0 && press_cnt < hold_reg) begin
                res.event_code = EV_SHORT;
                res.key_id     = held_key;
                scan_st        = SCAN_IDLE;
                press_cnt      = '0;
                held_key       = KEY_NONE;
            end
            // at or past the hold count: holding every tick, release ends it
            if (scan_st == SCAN_LATCHED && press_cnt >= hold_reg) begin
                res.key_id = held_key;
                if (down != '0) begin
                    res.event_code = EV_HOLD;
                end else begin
                    res.event_code = EV_HOLD_END;
                    scan_st        = SCAN_IDLE;
                    press_cnt      = '0;
                    held_key       = KEY_NONE;
                end
            end
        end
        return res;
    endfunction

    // Wait before the next request: mostly a random draw, with bursts of back-to-back traffic.
    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(8, 64);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // ---------------------------------------------------------------- tick driver
    // Changes at the falling edge. A taken request draws a gap; with no gap the next
    // tick follows at once, so tvalid gets a single assignment per edge.
    always @(negedge i_clk) begin
        logic             next_valid;
        logic [KEY_W-1:0] next_keys;
        next_valid = i_s_tvalid;
        next_keys  = i_s_tdata[KEY_W-1:0];
        if (i_rst_n) begin
            if (i_s_tvalid && tick_accepted) begin
                next_valid = 1'b0;
                send_wait  = draw_wait(send_burst);
            end
            if (!next_valid) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_ticks.size() > 0) begin
                    next_valid = 1'b1;
                    next_keys  = pending_ticks.pop_front();
                end
            end
        end
        i_s_tvalid <= next_valid;
        i_s_tdata  <= {1'b0, next_keys};
    end

    // ---------------------------------------------------------------- result sink
    // Back-pressure: after each taken result, hold tready low for a drawn stall.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (result_taken) begin
                recv_wait = draw_wait(recv_burst);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    // Samples at the rising edge: config shadow, prediction per taken tick, result check.
    always @(posedge i_clk) begin
        t_kpc_result want;
        tick_accepted <= i_s_tvalid && o_s_tready;
        result_taken  <= o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE: begin
                        deb_reg = i_cfg_data[DEB_W-1:0];
                    end
                    CFG_HOLD: begin
                        hold_reg = i_cfg_data[TICK_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                expected_events.push_back(classify_tick(i_s_tdata[KEY_W-1:0]));
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result: tdata %h", o_m_tdata);
                    end
                end else begin
                    want = expected_events.pop_front();
                    if (o_m_tdata !== {3'b000, want.key_id, want.event_code}) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("result mismatch: expected event %0d key %0d, got event %0d key %0d pad %b",
                                     want.event_code, want.key_id, o_m_tdata[1:0],
                                     o_m_tdata[4:2], o_m_tdata[7:5]);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: any handshake counts as progress.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic push_ticks(input logic [KEY_W-1:0] level, input int count);
        repeat (count) pending_ticks.push_back(level);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Debounce register is 8 bit; junk in the upper data bits must be dropped.
    task automatic set_timing(input int deb, input int hold);
        logic [CFG_DATA_W-1:0] word;
        word      = CFG_DATA_W'($urandom);
        word[7:0] = DEB_W'(deb);
        write_reg(CFG_DEBOUNCE, word);
        write_reg(CFG_HOLD, CFG_DATA_W'(hold));
    endtask

    // Idle between phases: every tick sent, every result back, then SETTLE_CYCLES quiet cycles.
    task automatic drain();
        while (pending_ticks.size() > 0 || i_s_tvalid || expected_events.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly clean presses sized around the debounce and hold counts, some with keys
    // changing or bouncing mid-press, plus stretches of random levels.
    task automatic key_sessions(input int deb, input int hold, input int budget);
        int               sent;
        int               len;
        int               pick;
        logic [KEY_W-1:0] held;
        logic [KEY_W-1:0] level;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) < 2) begin
                len = $urandom_range(1, 8);
                repeat (len) pending_ticks.push_back(KEY_W'($urandom_range(0, 127)));
                sent += len;
            end else begin
                len = $urandom_range(1, 4);
                push_ticks(ALL_UP, len);
                sent += len;
                held = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
                if ($urandom_range(0, 2) == 0) begin
                    held |= KEY_W'($urandom_range(1, 127));
                end
                case ($urandom_range(0, 2))
                    0:       len = $urandom_range(1, deb + 1);   // bounce around debounce end
                    1:       len = $urandom_range(deb, hold + 1); // short press region
                    default: len = hold + $urandom_range(0, 12);  // into hold
                endcase
                for (int t = 0; t < len; t++) begin
                    pick  = $urandom_range(0, 15);
                    level = ~held;
                    if (pick == 0) begin
                        level = ALL_UP;
                    end else if (pick < 3) begin
                        level = ~(held | KEY_W'($urandom_range(0, 127)));
                    end
                    pending_ticks.push_back(level);
                end
                pending_ticks.push_back(ALL_UP);
                sent += len + 1;
            end
        end
    endtask

    initial begin
        int               deb_tab[8]  = '{3, 1, 0, 6, 12, 0, 0, 255};
        int               hold_tab[8] = '{20, 2, 0, 3, 60, 1, 0, 270};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset timing: right key, released well before hold -> short press
        push_ticks(7'b1110111, 6);
        push_ticks(ALL_UP, 1);
        drain();

        // debounce 2, hold 4
        set_timing(2, 4);
        push_ticks(7'b0000000, 3);  // every key low: up wins
        push_ticks(ALL_UP, 1);
        push_ticks(7'b0111111, 6);  // last key held past hold count
        push_ticks(ALL_UP, 1);
        push_ticks(7'b1101111, 1);  // center gone before debounce end
        push_ticks(ALL_UP, 2);
        drain();

        // random phases, including zero counts and hold not above debounce
        deb_tab[6]  = $urandom_range(1, 15);
        hold_tab[6] = $urandom_range(2, 40);
        for (int p = 0; p < 8; p++) begin
            set_timing(deb_tab[p], hold_tab[p]);
            key_sessions(deb_tab[p], hold_tab[p], PHASE_TICKS);
            drain();
        end

        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
